@@ sv/tsam_pkg.sv @@
`timescale 1ns / 1ps

package tsam_pkg;

  localparam int COORD_W = 12;
  localparam int DIV_NW  = 24;
  localparam int DIV_DW  = 12;
  localparam int DIV_CW  = $clog2(DIV_NW);

  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [2:0] REG_X_RAW_LOW   = 3'd0;
  localparam logic [2:0] REG_X_RAW_HIGH  = 3'd1;
  localparam logic [2:0] REG_Y_RAW_LOW   = 3'd2;
  localparam logic [2:0] REG_Y_RAW_HIGH  = 3'd3;
  localparam logic [2:0] REG_SCR_X_MAX   = 3'd4;
  localparam logic [2:0] REG_SCR_Y_MAX   = 3'd5;
  localparam logic [2:0] REG_PRESS_THR   = 3'd6;

  localparam logic [COORD_W-1:0] RST_RAW_LOW  = 12'd150;
  localparam logic [COORD_W-1:0] RST_RAW_HIGH = 12'd3950;
  localparam logic [COORD_W-1:0] RST_SCR_X    = 12'd319;
  localparam logic [COORD_W-1:0] RST_SCR_Y    = 12'd239;
  localparam logic [COORD_W-1:0] RST_PRESS    = 12'd50;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_PAIR  = 1'b1;

  typedef struct packed {
    logic clr;
    logic add;
    logic go;
  } lane_ctl_t;

endpackage

@@ sv/touch_sample_average_map.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// in_      | slave     | tuser: req_type; tdata: pen_irq_level, pressure_raw, sample_x, sample_y
// out_     | master    | tuser: pressed; tdata: screen_x, screen_y
// cfg_     | APB       | seven 12-bit registers at byte address 4*i
//
// A frame start or a pair that does not close a frame is taken in the idle state. The pair
// that closes a frame stalls the input while each lane averages the sum by reciprocal
// multiply, offsets it, forms the scaled product, runs the serial divide by the
// calibration span and returns the coordinate.
// Synchronous active-low reset clears frame state, lanes and the output valid flag.
// Input stalls while a result is held and out_tready is low.

module touch_sample_average_map
  import tsam_pkg::*;
#(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // pen_irq_level, pressure_raw, sample_x, sample_y, pad
  input  logic              in_tuser,   // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // screen_x, screen_y
  output logic              out_tuser,  // pressed
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } top_st_t;

  top_st_t            st_r, st_nxt;
  logic               open_r, open_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovld_r, ovld_nxt;
  logic               opress_r, opress_nxt;
  logic [COORD_W-1:0] ox_r, ox_nxt;
  logic [COORD_W-1:0] oy_r, oy_nxt;

  logic [COORD_W-1:0] xlo_r, xhi_r, ylo_r, yhi_r, xmax_r, ymax_r, thr_r;

  logic               pen;
  logic [COORD_W-1:0] press;
  logic [COORD_W-1:0] smp_x;
  logic [COORD_W-1:0] smp_y;
  logic               in_xfer;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  lane_ctl_t          ctl;
  logic               lx_done, ly_done;
  logic [COORD_W-1:0] lx_coord, ly_coord;
  logic [CNT_W-1:0]   cnt_inc;

  assign pen     = in_tdata[0];
  assign press   = in_tdata[12:1];
  assign smp_x   = in_tdata[24:13];
  assign smp_y   = in_tdata[36:25];
  assign in_tready = (st_r == S_IDLE) && (!ovld_r || out_tready);
  assign in_xfer = in_tvalid && in_tready;
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    st_nxt     = st_r;
    open_nxt   = open_r;
    cnt_nxt    = cnt_r;
    ovld_nxt   = ovld_r && !out_tready;
    opress_nxt = opress_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    ctl        = '0;
    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == REQ_FRAME) begin
            ctl.clr = 1'b1;
            cnt_nxt = '0;
            if (pen || press < thr_r) begin
              open_nxt   = 1'b0;
              ovld_nxt   = 1'b1;
              opress_nxt = 1'b0;
              ox_nxt     = '0;
              oy_nxt     = '0;
            end else begin
              open_nxt = 1'b1;
            end
          end else if (open_r) begin
            ctl.add = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_inc == CNT_W'(SAMPLE_COUNT)) begin
              ctl.go   = 1'b1;
              open_nxt = 1'b0;
              cnt_nxt  = '0;
              st_nxt   = S_CALC;
            end
          end
        end
      end
      S_CALC: begin
        if (lx_done && ly_done) begin
          ovld_nxt   = 1'b1;
          opress_nxt = 1'b1;
          ox_nxt     = lx_coord;
          oy_nxt     = ly_coord;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      open_r <= 1'b0;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
    opress_r <= opress_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
  end

  tsam_lane #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (smp_y),
    .raw_lo (ylo_r),
    .raw_hi (yhi_r),
    .top    (xmax_r),
    .done   (lx_done),
    .coord  (lx_coord)
  );

  tsam_lane #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (smp_x),
    .raw_lo (xlo_r),
    .raw_hi (xhi_r),
    .top    (ymax_r),
    .done   (ly_done),
    .coord  (ly_coord)
  );

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlo_r  <= RST_RAW_LOW;
      xhi_r  <= RST_RAW_HIGH;
      ylo_r  <= RST_RAW_LOW;
      yhi_r  <= RST_RAW_HIGH;
      xmax_r <= RST_SCR_X;
      ymax_r <= RST_SCR_Y;
      thr_r  <= RST_PRESS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_X_RAW_LOW:  xlo_r  <= cfg_pwdata[COORD_W-1:0];
        REG_X_RAW_HIGH: xhi_r  <= cfg_pwdata[COORD_W-1:0];
        REG_Y_RAW_LOW:  ylo_r  <= cfg_pwdata[COORD_W-1:0];
        REG_Y_RAW_HIGH: yhi_r  <= cfg_pwdata[COORD_W-1:0];
        REG_SCR_X_MAX:  xmax_r <= cfg_pwdata[COORD_W-1:0];
        REG_SCR_Y_MAX:  ymax_r <= cfg_pwdata[COORD_W-1:0];
        REG_PRESS_THR:  thr_r  <= cfg_pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_X_RAW_LOW:  cfg_prdata = CFG_DW'(xlo_r);
      REG_X_RAW_HIGH: cfg_prdata = CFG_DW'(xhi_r);
      REG_Y_RAW_LOW:  cfg_prdata = CFG_DW'(ylo_r);
      REG_Y_RAW_HIGH: cfg_prdata = CFG_DW'(yhi_r);
      REG_SCR_X_MAX:  cfg_prdata = CFG_DW'(xmax_r);
      REG_SCR_Y_MAX:  cfg_prdata = CFG_DW'(ymax_r);
      REG_PRESS_THR:  cfg_prdata = CFG_DW'(thr_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = opress_r;
  assign out_tdata  = {oy_r, ox_r};

endmodule

@@ sv/tsam_div.sv @@
`timescale 1ns / 1ps

module tsam_div
  import tsam_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   diff;

  always_comb begin
    sh       = {rem_r, quo_r[DIV_NW-1]};
    diff     = sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DIV_NW - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/tsam_lane.sv @@
`timescale 1ns / 1ps

module tsam_lane
  import tsam_pkg::*;
#(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic [COORD_W-1:0] sample,
  input  logic [COORD_W-1:0] raw_lo,
  input  logic [COORD_W-1:0] raw_hi,
  input  logic [COORD_W-1:0] top,
  output logic               done,
  output logic [COORD_W-1:0] coord
);

  localparam int SUM_W  = COORD_W + $clog2(SAMPLE_COUNT);
  localparam int AVG_SH = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int AVG_MW = SUM_W + 1;
  localparam int AVG_PW = 2 * SUM_W + 1;
  localparam logic [AVG_MW-1:0] AVG_MUL =
    AVG_MW'(((longint'(1) << AVG_SH) + longint'(SAMPLE_COUNT) - 1) / longint'(SAMPLE_COUNT));
  localparam logic [COORD_W-1:0] SMP_MASK = (SAMPLE_BITS >= COORD_W) ? {COORD_W{1'b1}} :
                                            COORD_W'((1 << SAMPLE_BITS) - 1);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_AVG  = 5'b00010,
    L_DIF  = 5'b00100,
    L_MUL  = 5'b01000,
    L_MAP  = 5'b10000
  } lane_st_t;

  lane_st_t           st_r, st_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COORD_W-1:0] avg_r, avg_nxt;
  logic [COORD_W-1:0] dif_r, dif_nxt;
  logic [COORD_W-1:0] span_r, span_nxt;
  logic               skip_r, skip_nxt;
  logic [COORD_W-1:0] coord_r, coord_nxt;
  logic               done_r, done_nxt;

  logic               div_start;
  logic [DIV_NW-1:0]  div_nd;
  logic [DIV_DW-1:0]  div_dv;
  logic               div_done;
  logic [DIV_NW-1:0]  div_q;
  logic [AVG_PW-1:0]  avg_prod;
  logic [COORD_W:0]   d_ext;
  logic [COORD_W:0]   s_ext;
  logic [DIV_NW-1:0]  prod;

  tsam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_nd),
    .divisor  (div_dv),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clr) begin
      sum_nxt = '0;
    end else if (ctl.add) begin
      sum_nxt = sum_r + SUM_W'(sample & SMP_MASK);
    end
  end

  always_comb begin
    avg_prod  = AVG_PW'(sum_r) * AVG_PW'(AVG_MUL);
    d_ext     = {1'b0, avg_r} - {1'b0, raw_lo};
    s_ext     = {1'b0, raw_hi} - {1'b0, raw_lo};
    prod      = DIV_NW'(dif_r) * DIV_NW'(top);
    st_nxt    = st_r;
    avg_nxt   = avg_r;
    dif_nxt   = dif_r;
    span_nxt  = span_r;
    skip_nxt  = skip_r;
    coord_nxt = coord_r;
    done_nxt  = 1'b0;
    div_start = 1'b0;
    div_nd    = prod;
    div_dv    = span_r;
    case (st_r)
      L_IDLE: begin
        if (ctl.go) begin
          st_nxt = L_AVG;
        end
      end
      L_AVG: begin
        avg_nxt = avg_prod[AVG_SH +: COORD_W];
        st_nxt  = L_DIF;
      end
      L_DIF: begin
        dif_nxt  = d_ext[COORD_W-1:0];
        span_nxt = s_ext[COORD_W-1:0];
        skip_nxt = d_ext[COORD_W] | s_ext[COORD_W] | (s_ext == '0);
        st_nxt   = L_MUL;
      end
      L_MUL: begin
        div_start = 1'b1;
        st_nxt    = L_MAP;
      end
      L_MAP: begin
        if (div_done) begin
          if (skip_r) begin
            coord_nxt = '0;
          end else if (div_q > DIV_NW'(top)) begin
            coord_nxt = top;
          end else begin
            coord_nxt = div_q[COORD_W-1:0];
          end
          done_nxt = 1'b1;
          st_nxt   = L_IDLE;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      sum_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sum_r  <= sum_nxt;
      done_r <= done_nxt;
    end
    avg_r   <= avg_nxt;
    dif_r   <= dif_nxt;
    span_r  <= span_nxt;
    skip_r  <= skip_nxt;
    coord_r <= coord_nxt;
  end

  assign done  = done_r;
  assign coord = coord_r;

endmodule
